// ===== sv/mpsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsp_pkg
// Shared types and codes for the packet stream parser.
// ----------------------------------------------------------------------------
package mpsp_pkg;

   localparam int HdrBytes = 58;
   localparam int MsgBytes = 14;
   localparam int RunMax   = 22;

   localparam logic [2:0] EV_HDR_WORD = 3'd0;
   localparam logic [2:0] EV_MSG_WORD = 3'd1;
   localparam logic [2:0] EV_STR_BYTE = 3'd2;
   localparam logic [2:0] EV_STR_END  = 3'd3;
   localparam logic [2:0] EV_DONE     = 3'd4;
   localparam logic [2:0] EV_ERROR    = 3'd5;

   localparam logic [2:0] ERR_SMALL    = 3'd0;
   localparam logic [2:0] ERR_VERSION  = 3'd1;
   localparam logic [2:0] ERR_CAP      = 3'd2;
   localparam logic [2:0] ERR_MSG_TYPE = 3'd3;
   localparam logic [2:0] ERR_MSG_TRUNC = 3'd4;
   localparam logic [2:0] ERR_DATE_TRUNC = 3'd5;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_MSG    = 5'b00010,
      PH_DATE   = 5'b00100,
      PH_STR    = 5'b01000,
      PH_IDLE   = 5'b10000
   } phase_type;

   // one result run, decoded from one request
   typedef struct packed {
      logic       hdr_run;    // 21 header words
      logic       msg_run;    // 6 message words
      logic       lead_valid; // single byte/end event first
      logic [2:0] lead_kind;
      logic [4:0] lead_id;
      logic [7:0] lead_val;
      logic       extra_end;  // date end at 20th byte
      logic [2:0] empty_from; // bare string ends from here to 4 (0 = none)
      logic       done;
      logic       err;
      logic [2:0] err_code;
      logic [1:0] pkind;
   } run_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  id;
      logic [15:0] value;
      logic [1:0]  pkind;
      logic [2:0]  err;
      logic        last;
   } result_type;

endpackage

// ===== sv/mpsp_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsp_decode
// Byte parser: holds header buffers and phase, builds one run per request.
// ----------------------------------------------------------------------------
module mpsp_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   output mpsp_pkg::run_type      run,
   output logic                   run_any,
   output logic [15:0]            hdr_word [21],
   output logic [15:0]            msg_word [6]
);

   logic [7:0] hdr_ff [mpsp_pkg::HdrBytes];
   logic [7:0] msg_ff [mpsp_pkg::MsgBytes];
   logic [5:0] pos_ff, pos_in;
   mpsp_pkg::phase_type phase_ff, phase_in;
   logic [2:0] sn_ff, sn_in;
   logic       dend_ff, dend_in;
   logic [1:0] kind_ff, kind_in;

   logic [15:0] hw [27];
   logic [15:0] m0, cap, capv, swp;
   logic [2:0]  sn;

   always_comb begin
      for (int i = 0; i < 27; i++) begin
         hw[i] = {hdr_ff[2*i+1], hdr_ff[2*i]};
      end
      m0  = {msg_ff[1], msg_ff[0]};
      cap = hw[22];
      capv = hw[20];
      swp = {cap[7:0], cap[15:8]};
      for (int i = 0; i < 6; i++) begin
         msg_word[i] = (i == 5) ? {data_byte, msg_ff[12]}
                                : {msg_ff[2*i+3], msg_ff[2*i+2]};
      end
   end

   always_comb begin
      for (int i = 0; i < 21; i++) hdr_word[i] = 16'd0;
      for (int i = 0; i < 9; i++) hdr_word[i] = hw[i];
      hdr_word[10] = hw[11];
      hdr_word[11] = hw[12];
      if (cap == 16'd0) begin
         hdr_word[9]  = hw[10];
         hdr_word[12] = hw[17];
         hdr_word[13] = hw[18];
      end else begin
         hdr_word[14] = hw[17];
         hdr_word[15] = hw[18];
         hdr_word[16] = hw[19];
         hdr_word[17] = hw[21];
         hdr_word[18] = cap;
         hdr_word[12] = hw[23];
         hdr_word[13] = hw[24];
         hdr_word[19] = hw[25];
         hdr_word[20] = hw[26];
         hdr_word[9]  = (hw[10] == 16'hFFFF && hw[25] != 16'd0) ? hw[19] : hw[10];
      end
   end

   always_comb begin
      run = '0;
      run.pkind = kind_ff;
      pos_in = pos_ff;
      phase_in = phase_ff;
      sn_in = sn_ff;
      dend_in = dend_ff;
      kind_in = kind_ff;
      sn = (sn_ff < 3'd1) ? 3'd1 : ((sn_ff > 3'd4) ? 3'd4 : sn_ff);
      unique case (phase_ff)
         mpsp_pkg::PH_HEADER: begin
            if (pos_ff < 6'd57) begin
               pos_in = pos_ff + 6'd1;
               if (final_byte) begin
                  run.err = 1'b1;
                  run.err_code = mpsp_pkg::ERR_SMALL;
               end
            end else if (hw[9] != 16'h0002) begin
               run.err = 1'b1;
               run.err_code = mpsp_pkg::ERR_VERSION;
               phase_in = mpsp_pkg::PH_IDLE;
            end else if (cap != 16'd0 && swp != capv) begin
               run.err = 1'b1;
               run.err_code = mpsp_pkg::ERR_CAP;
               phase_in = mpsp_pkg::PH_IDLE;
            end else begin
               if (cap == 16'd0) kind_in = 2'd0;
               else if (hw[10] == 16'hFFFF && hw[25] != 16'd0) kind_in = 2'd2;
               else kind_in = 2'd1;
               run.pkind = kind_in;
               run.hdr_run = 1'b1;
               run.done = final_byte;
               phase_in = mpsp_pkg::PH_MSG;
               pos_in = 6'd0;
            end
         end
         mpsp_pkg::PH_MSG: begin
            if (pos_ff == 6'd0) begin
               if (final_byte) run.done = 1'b1;
               else pos_in = 6'd1;
            end else if (pos_ff == 6'd1 && {data_byte, msg_ff[0]} == 16'd0) begin
               run.done = 1'b1;
               phase_in = mpsp_pkg::PH_IDLE;
            end else if (pos_ff < 6'd13) begin
               if (final_byte) begin
                  run.err = 1'b1;
                  run.err_code = mpsp_pkg::ERR_MSG_TRUNC;
               end else pos_in = pos_ff + 6'd1;
            end else if (m0 != 16'h0002) begin
               run.err = 1'b1;
               run.err_code = mpsp_pkg::ERR_MSG_TYPE;
               phase_in = mpsp_pkg::PH_IDLE;
            end else begin
               run.msg_run = 1'b1;
               phase_in = mpsp_pkg::PH_DATE;
               pos_in = 6'd0;
               dend_in = 1'b0;
               if (final_byte) begin
                  run.err = 1'b1;
                  run.err_code = mpsp_pkg::ERR_DATE_TRUNC;
               end
            end
         end
         mpsp_pkg::PH_DATE: begin
            if (!dend_ff) begin
               run.lead_valid = 1'b1;
               run.lead_val = data_byte;
               if (data_byte == 8'd0) begin
                  run.lead_kind = mpsp_pkg::EV_STR_END;
                  dend_in = 1'b1;
               end else run.lead_kind = mpsp_pkg::EV_STR_BYTE;
            end
            if (pos_ff >= 6'd19) begin
               run.extra_end = !dend_in;
               phase_in = mpsp_pkg::PH_STR;
               sn_in = 3'd1;
               pos_in = 6'd0;
               if (final_byte) begin
                  run.empty_from = 3'd1;
                  run.done = 1'b1;
               end
            end else begin
               pos_in = pos_ff + 6'd1;
               if (final_byte) begin
                  run.err = 1'b1;
                  run.err_code = mpsp_pkg::ERR_DATE_TRUNC;
               end
            end
         end
         mpsp_pkg::PH_STR: begin
            run.lead_valid = 1'b1;
            run.lead_id = {2'b00, sn};
            run.lead_val = data_byte;
            if (data_byte != 8'd0) begin
               run.lead_kind = mpsp_pkg::EV_STR_BYTE;
               if (final_byte) begin
                  run.empty_from = sn;
                  run.done = 1'b1;
               end
            end else begin
               run.lead_kind = mpsp_pkg::EV_STR_END;
               if (sn >= 3'd4) begin
                  phase_in = mpsp_pkg::PH_MSG;
                  pos_in = 6'd0;
                  sn_in = 3'd0;
                  run.done = final_byte;
               end else begin
                  sn_in = sn + 3'd1;
                  if (final_byte) begin
                     run.empty_from = sn + 3'd1;
                     run.done = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      if (run.lead_kind == mpsp_pkg::EV_STR_END) run.lead_val = 8'd0;
      if (final_byte) begin
         pos_in = 6'd0;
         phase_in = mpsp_pkg::PH_HEADER;
         sn_in = 3'd0;
         dend_in = 1'b0;
         kind_in = 2'd0;
      end
   end

   assign run_any = run.hdr_run | run.msg_run | run.lead_valid | run.done | run.err;

   always_ff @(posedge clock) begin
      if (accept) begin
         if (phase_ff == mpsp_pkg::PH_HEADER) hdr_ff[pos_ff] <= data_byte;
         if (phase_ff == mpsp_pkg::PH_MSG)
            msg_ff[(pos_ff > 6'd13) ? 4'd13 : pos_ff[3:0]] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= mpsp_pkg::PH_HEADER;
         sn_ff <= '0;
         dend_ff <= 1'b0;
         kind_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         sn_ff <= sn_in;
         dend_ff <= dend_in;
         kind_ff <= kind_in;
      end
   end

endmodule

// ===== sv/mpsp_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsp_emit
// Run register: holds one decoded run, plays it out one result per ready cycle.
// ----------------------------------------------------------------------------
module mpsp_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  mpsp_pkg::run_type      run,
   input  logic [15:0]            hdr_word [21],
   input  logic [15:0]            msg_word [6],
   output logic                   busy,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mpsp_pkg::result_type   out_res
);

   localparam int SlotMax = mpsp_pkg::RunMax;

   mpsp_pkg::result_type slot_ff [SlotMax];
   mpsp_pkg::result_type slot_in [SlotMax];
   logic [4:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [4:0] n;

   function automatic mpsp_pkg::result_type mk(logic [2:0] k, logic [4:0] id,
         logic [15:0] v, logic [1:0] pk, logic [2:0] e);
      mpsp_pkg::result_type r;
      r.kind = k; r.id = id; r.value = v; r.pkind = pk; r.err = e; r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      n = 5'd0;
      for (int i = 0; i < SlotMax; i++) slot_in[i] = '0;
      if (run.hdr_run) begin
         for (int i = 0; i < 21; i++)
            slot_in[i] = mk(mpsp_pkg::EV_HDR_WORD, 5'(i), hdr_word[i], run.pkind, 3'd0);
         n = 5'd21;
      end
      if (run.msg_run) begin
         for (int i = 0; i < 6; i++)
            slot_in[i] = mk(mpsp_pkg::EV_MSG_WORD, 5'(21 + i), msg_word[i], run.pkind, 3'd0);
         n = 5'd6;
      end
      if (run.lead_valid) begin
         slot_in[0] = mk(run.lead_kind, run.lead_id, {8'd0, run.lead_val}, run.pkind, 3'd0);
         n = 5'd1;
         if (run.extra_end) begin
            slot_in[1] = mk(mpsp_pkg::EV_STR_END, 5'd0, 16'd0, run.pkind, 3'd0);
            n = 5'd2;
         end
      end
      // bare string ends; n is at most 2 here
      if (run.empty_from != 3'd0) begin
         for (int s = 1; s <= 4; s++) begin
            if (3'(s) >= run.empty_from) begin
               slot_in[n] = mk(mpsp_pkg::EV_STR_END, 5'(s), 16'd0, run.pkind, 3'd0);
               n = n + 5'd1;
            end
         end
      end
      if (run.done) begin
         slot_in[n] = mk(mpsp_pkg::EV_DONE, 5'd0, 16'd0, run.pkind, 3'd0);
         n = n + 5'd1;
      end else if (run.err) begin
         slot_in[n] = mk(mpsp_pkg::EV_ERROR, 5'd0, 16'd0, run.pkind, run.err_code);
         n = n + 5'd1;
      end
      if (n != 5'd0) slot_in[n - 5'd1].last = 1'b1;
   end

   assign out_valid = (idx_ff != cnt_ff);
   assign out_res = slot_ff[idx_ff];
   // free when empty or on the last pop
   assign busy = out_valid && !(out_ready && (idx_ff + 5'd1 == cnt_ff));

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (out_valid && out_ready) idx_in = idx_ff + 5'd1;
      if (load) begin
         idx_in = 5'd0;
         cnt_in = n;
      end
   end

   always_ff @(posedge clock) begin
      if (load) slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/message_packet_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_packet_stream_parser
// Type-2 family packet parser: bytes in, header/message/string events out.
// ----------------------------------------------------------------------------
// One request byte is taken per cycle while not busy. A byte that yields
// results loads a run register and the run plays out one result per cycle
// while rsp_tready is high (up to 22 for the packet header); a new request is
// taken in the cycle the run's last result is taken; run length sets the stall.
module message_packet_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // event_kind, field_id, field_value, packet_kind, error_code
   output logic        rsp_tlast    // run_last
);

   mpsp_pkg::run_type    run;
   mpsp_pkg::result_type res;
   logic        run_any, busy, accept;
   logic [15:0] hdr_word [21];
   logic [15:0] msg_word [6];

   assign req_tready = !busy;
   assign accept = req_tvalid && req_tready;

   mpsp_decode u_decode (
      .clock(clock), .reset(reset), .accept(accept),
      .data_byte(req_tdata), .final_byte(req_tlast),
      .run(run), .run_any(run_any), .hdr_word(hdr_word), .msg_word(msg_word)
   );

   mpsp_emit u_emit (
      .clock(clock), .reset(reset), .load(accept && run_any), .run(run),
      .hdr_word(hdr_word), .msg_word(msg_word), .busy(busy),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {3'd0, res.err, res.pkind, res.value, res.id, res.kind};
   assign rsp_tlast = res.last;

endmodule
